// ----- src/assert_macros.svh -----
// Shared assertion helpers for the triangle normal checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TFN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tfn_pkg.sv -----
package tfn_pkg;

  localparam int IN_W       = 32;
  localparam int OUT_W      = 16;
  localparam int NORM_TOP   = 29;
  localparam int V_W        = NORM_TOP + 1;
  localparam int SQ_W       = 2 * V_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int L_W        = SQRT_STEPS;
  localparam int ONE_SH     = 14;
  localparam int Q_W        = ONE_SH + 1;
  localparam int DIV_STEPS  = Q_W;
  localparam int REM_W      = V_W + ONE_SH + 2;

  typedef struct packed {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
    logic signed [IN_W-1:0] bx;
    logic signed [IN_W-1:0] by;
    logic signed [IN_W-1:0] bz;
    logic signed [IN_W-1:0] cx;
    logic signed [IN_W-1:0] cy;
    logic signed [IN_W-1:0] cz;
    logic                   final_triangle;
  } tfn_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
    logic signed [OUT_W-1:0] norm_z;
    logic                    degenerate;
    logic                    vertex_last;
    logic                    end_of_mesh;
  } tfn_out_t;

  // valid bit and end-of-mesh flag riding along with each triangle
  typedef struct packed {
    logic valid;
    logic fin;
  } tfn_ctl_t;

  // per-triangle data carried through the sqrt and divide stages
  typedef struct packed {
    logic [2:0]          neg;
    logic                degen;
    logic [2:0][V_W-1:0] v;
  } tfn_side_t;

endpackage

// ----- src/tfn_cross.sv -----
module tfn_cross import tfn_pkg::*; #(
  parameter int CW  = 32,
  parameter int N_W = 2 * (CW + 1) + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  tfn_in_t               in_data,
  output tfn_ctl_t              ctl_o,
  output logic signed [N_W-1:0] n_o [3]
);

  localparam int E_W = CW + 1;
  localparam int P_W = 2 * E_W;

  tfn_ctl_t ctl1_r, ctl2_r, ctl3_r;
  logic signed [E_W-1:0] e_nxt [3];
  logic signed [E_W-1:0] f_nxt [3];
  logic signed [E_W-1:0] e_r [3];
  logic signed [E_W-1:0] f_r [3];
  logic signed [P_W-1:0] p_r [6];
  logic signed [N_W-1:0] n_r [3];

  always_comb begin
    e_nxt[0] = E_W'($signed(in_data.bx[CW-1:0])) - E_W'($signed(in_data.ax[CW-1:0]));
    e_nxt[1] = E_W'($signed(in_data.by[CW-1:0])) - E_W'($signed(in_data.ay[CW-1:0]));
    e_nxt[2] = E_W'($signed(in_data.bz[CW-1:0])) - E_W'($signed(in_data.az[CW-1:0]));
    f_nxt[0] = E_W'($signed(in_data.cx[CW-1:0])) - E_W'($signed(in_data.ax[CW-1:0]));
    f_nxt[1] = E_W'($signed(in_data.cy[CW-1:0])) - E_W'($signed(in_data.ay[CW-1:0]));
    f_nxt[2] = E_W'($signed(in_data.cz[CW-1:0])) - E_W'($signed(in_data.az[CW-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      ctl1_r <= '{valid: in_valid, fin: in_data.final_triangle};
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r    <= e_nxt;
      f_r    <= f_nxt;
      p_r[0] <= e_r[1] * f_r[2];
      p_r[1] <= e_r[2] * f_r[1];
      p_r[2] <= e_r[2] * f_r[0];
      p_r[3] <= e_r[0] * f_r[2];
      p_r[4] <= e_r[0] * f_r[1];
      p_r[5] <= e_r[1] * f_r[0];
      n_r[0] <= N_W'(p_r[0]) - N_W'(p_r[1]);
      n_r[1] <= N_W'(p_r[2]) - N_W'(p_r[3]);
      n_r[2] <= N_W'(p_r[4]) - N_W'(p_r[5]);
    end
  end

  assign ctl_o = ctl3_r;
  assign n_o   = n_r;

endmodule

// ----- src/tfn_scale.sv -----
module tfn_scale import tfn_pkg::*; #(
  parameter int N_W = 67
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  tfn_ctl_t              ctl_i,
  input  logic signed [N_W-1:0] n_i [3],
  output tfn_ctl_t              ctl_o,
  output tfn_side_t             side_o,
  output logic [SUM_W-1:0]      sum_o
);

  localparam int TOP_W = $clog2(N_W);

  tfn_ctl_t ctl_r [5];
  logic [2:0]       neg_r [5];
  logic             degen_r [4];
  logic [N_W-1:0]   mag_r [2][3];
  logic [N_W-1:0]   or_r;
  logic [TOP_W-1:0] top_r, top_nxt;
  logic [V_W-1:0]   v_r [3][3];
  logic [V_W-1:0]   v_nxt [3];
  logic [SQ_W-1:0]  sq_r [3];
  logic [SUM_W-1:0] sum_r;
  tfn_side_t        side_r;

  // leading-one position of the OR of the three magnitudes
  always_comb begin
    top_nxt = '0;
    for (int i = 0; i < N_W; i++) begin
      if (or_r[i]) top_nxt = TOP_W'(i);
    end
  end

  // bring the leading one to bit NORM_TOP, truncating on a right shift
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (top_r > TOP_W'(NORM_TOP))
        v_nxt[l] = V_W'(mag_r[1][l] >> (top_r - TOP_W'(NORM_TOP)));
      else
        v_nxt[l] = V_W'(mag_r[1][l] << (TOP_W'(NORM_TOP) - top_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) ctl_r[k] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
      for (int k = 1; k < 5; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        neg_r[0][l] <= n_i[l][N_W-1];
        mag_r[0][l] <= n_i[l][N_W-1] ? N_W'(-n_i[l]) : N_W'(n_i[l]);
      end
      or_r <= (n_i[0][N_W-1] ? N_W'(-n_i[0]) : N_W'(n_i[0])) |
              (n_i[1][N_W-1] ? N_W'(-n_i[1]) : N_W'(n_i[1])) |
              (n_i[2][N_W-1] ? N_W'(-n_i[2]) : N_W'(n_i[2]));
      for (int k = 1; k < 5; k++) neg_r[k] <= neg_r[k-1];
      top_r      <= top_nxt;
      degen_r[0] <= (or_r == '0);
      degen_r[1] <= degen_r[0];
      degen_r[2] <= degen_r[1];
      degen_r[3] <= degen_r[2];
      mag_r[1]   <= mag_r[0];
      v_r[0]     <= v_nxt;
      v_r[1]     <= v_r[0];
      v_r[2]     <= v_r[1];
      for (int l = 0; l < 3; l++) sq_r[l] <= v_r[0][l] * v_r[0][l];
      sum_r      <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    end
  end

  // side data leaves in step with sum_r
  always_comb begin
    side_r.neg   = neg_r[4];
    side_r.degen = degen_r[3];
    for (int l = 0; l < 3; l++) side_r.v[l] = v_r[2][l];
  end

  assign ctl_o  = ctl_r[4];
  assign side_o = side_r;
  assign sum_o  = sum_r;

endmodule

// ----- src/tfn_sqrt.sv -----
module tfn_sqrt import tfn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  tfn_ctl_t         ctl_i,
  input  tfn_side_t        side_i,
  input  logic [SUM_W-1:0] sum_i,
  output tfn_ctl_t         ctl_o,
  output tfn_side_t        side_o,
  output logic [L_W-1:0]   len_o
);

  // one result bit per stage, highest bit first
  tfn_ctl_t         ctl_r  [SQRT_STEPS];
  tfn_side_t        side_r [SQRT_STEPS];
  logic [SUM_W-1:0] rad_r  [SQRT_STEPS];
  logic [SUM_W-1:0] root_r [SQRT_STEPS];
  logic [SUM_W-1:0] rad_nxt  [SQRT_STEPS];
  logic [SUM_W-1:0] root_nxt [SQRT_STEPS];

  always_comb begin
    logic [SUM_W-1:0] rad, root, bitv, trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      rad   = (k == 0) ? sum_i : rad_r[(k == 0) ? 0 : k-1];
      root  = (k == 0) ? '0    : root_r[(k == 0) ? 0 : k-1];
      bitv  = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      trial = root + bitv;
      if (rad >= trial) begin
        rad_nxt[k]  = rad - trial;
        root_nxt[k] = (root >> 1) + bitv;
      end else begin
        rad_nxt[k]  = rad;
        root_nxt[k] = root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STEPS; k++) ctl_r[k] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
      for (int k = 1; k < SQRT_STEPS; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r     <= rad_nxt;
      root_r    <= root_nxt;
      side_r[0] <= side_i;
      for (int k = 1; k < SQRT_STEPS; k++) side_r[k] <= side_r[k-1];
    end
  end

  assign ctl_o  = ctl_r[SQRT_STEPS-1];
  assign side_o = side_r[SQRT_STEPS-1];
  assign len_o  = root_r[SQRT_STEPS-1][L_W-1:0];

endmodule

// ----- src/tfn_div.sv -----
module tfn_div import tfn_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  tfn_ctl_t       ctl_i,
  input  tfn_side_t      side_i,
  input  logic [L_W-1:0] len_i,
  output tfn_ctl_t       ctl_o,
  output tfn_side_t      side_o,
  output logic [Q_W-1:0] q_o [3]
);

  // restoring divide, three lanes, one quotient bit per stage
  tfn_ctl_t         ctl_r  [DIV_STEPS];
  tfn_side_t        side_r [DIV_STEPS];
  logic [L_W-1:0]   len_r  [DIV_STEPS];
  logic [REM_W-1:0] rem_r  [DIV_STEPS][3];
  logic [Q_W-1:0]   q_r    [DIV_STEPS][3];
  logic [REM_W-1:0] rem_nxt [DIV_STEPS][3];
  logic [Q_W-1:0]   q_nxt   [DIV_STEPS][3];

  always_comb begin
    logic [REM_W-1:0] rem, dsr;
    logic [Q_W-1:0]   q;
    logic [L_W-1:0]   len;
    for (int k = 0; k < DIV_STEPS; k++) begin
      len = (k == 0) ? len_i : len_r[(k == 0) ? 0 : k-1];
      dsr = REM_W'(len) << (DIV_STEPS - 1 - k);
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          // v * 2^14 plus half the length gives round half up
          rem = (REM_W'(side_i.v[l]) << ONE_SH) + REM_W'(len_i >> 1);
          q   = '0;
        end else begin
          rem = rem_r[(k == 0) ? 0 : k-1][l];
          q   = q_r[(k == 0) ? 0 : k-1][l];
        end
        if (rem >= dsr) begin
          rem_nxt[k][l] = rem - dsr;
          q_nxt[k][l]   = q | (Q_W'(1) << (DIV_STEPS - 1 - k));
        end else begin
          rem_nxt[k][l] = rem;
          q_nxt[k][l]   = q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STEPS; k++) ctl_r[k] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
      for (int k = 1; k < DIV_STEPS; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r     <= rem_nxt;
      q_r       <= q_nxt;
      len_r[0]  <= len_i;
      side_r[0] <= side_i;
      for (int k = 1; k < DIV_STEPS; k++) begin
        len_r[k]  <= len_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign ctl_o  = ctl_r[DIV_STEPS-1];
  assign side_o = side_r[DIV_STEPS-1];
  assign q_o    = q_r[DIV_STEPS-1];

endmodule

// ----- src/triangle_face_normal_core.sv -----
// Triangle face normal: takes a triangle (three Q16.16 vertices) and returns its unit normal
// in Q1.14 three times, the third copy flagged vertex_last (and end_of_mesh for a final
// triangle). A zero cross product returns a zero normal with degenerate set. From input
// transfer to the first result a triangle passes the cross product, then magnitude,
// normalizing shift and sum of squares, the bit-per-stage square root, the bit-per-stage
// divide and the output register. The pipeline takes a triangle in any cycle it is not
// held, but the output port sends three results per triangle, and no new triangle moves
// in while earlier copies of the last one are still to send. cfg_wr_en writes flip_normal,
// which negates non-degenerate normals; write it only while the block is idle.
module triangle_face_normal_core import tfn_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tfn_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tfn_out_t out_data,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  localparam int N_W = 2 * (COORD_WIDTH + 1) + 1;

  logic flip_r;
  logic en;

  tfn_ctl_t              c_ctl, s_ctl, q_ctl, d_ctl;
  logic signed [N_W-1:0] n_w [3];
  tfn_side_t             s_side, q_side, d_side;
  logic [SUM_W-1:0]      sum_w;
  logic [L_W-1:0]        len_w;
  logic [Q_W-1:0]        q_w [3];

  logic                    ser_v_r;
  logic [1:0]              cnt_r;
  logic signed [OUT_W-1:0] res_r [3];
  logic                    degen_r, fin_r;
  logic signed [OUT_W-1:0] res_nxt [3];
  logic                    take;

  always_ff @(posedge clk) begin
    if (!rst_n)         flip_r <= 1'b0;
    else if (cfg_wr_en) flip_r <= cfg_wr_data;
  end

  // pipeline moves whenever the serializer can take its last stage
  assign take     = !ser_v_r || (!out_stall && cnt_r == 2'd2);
  assign en       = take;
  assign in_stall = !en;

  tfn_cross #(.CW(COORD_WIDTH), .N_W(N_W)) u_cross (
    .clk, .rst_n, .en, .in_valid, .in_data, .ctl_o(c_ctl), .n_o(n_w)
  );

  tfn_scale #(.N_W(N_W)) u_scale (
    .clk, .rst_n, .en, .ctl_i(c_ctl), .n_i(n_w),
    .ctl_o(s_ctl), .side_o(s_side), .sum_o(sum_w)
  );

  tfn_sqrt u_sqrt (
    .clk, .rst_n, .en, .ctl_i(s_ctl), .side_i(s_side), .sum_i(sum_w),
    .ctl_o(q_ctl), .side_o(q_side), .len_o(len_w)
  );

  tfn_div u_div (
    .clk, .rst_n, .en, .ctl_i(q_ctl), .side_i(q_side), .len_i(len_w),
    .ctl_o(d_ctl), .side_o(d_side), .q_o(q_w)
  );

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (d_side.degen)
        res_nxt[l] = '0;
      else if (d_side.neg[l] ^ flip_r)
        res_nxt[l] = -$signed(OUT_W'(q_w[l]));
      else
        res_nxt[l] = $signed(OUT_W'(q_w[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      cnt_r   <= '0;
    end else if (take) begin
      ser_v_r <= d_ctl.valid;
      cnt_r   <= '0;
    end else if (!out_stall) begin
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r   <= res_nxt;
      degen_r <= d_side.degen;
      fin_r   <= d_ctl.fin;
    end
  end

  assign out_valid            = ser_v_r;
  assign out_data.norm_x      = res_r[0];
  assign out_data.norm_y      = res_r[1];
  assign out_data.norm_z      = res_r[2];
  assign out_data.degenerate  = degen_r;
  assign out_data.vertex_last = (cnt_r == 2'd2);
  assign out_data.end_of_mesh = (cnt_r == 2'd2) && fin_r;

endmodule

// ----- src/tfn_checker.sv -----
`include "assert_macros.svh"

module tfn_checker import tfn_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input tfn_out_t out_data
);

  `TFN_ASSERT_NOW(a_degen_zero, out_valid && out_data.degenerate, out_data.norm_x == 0 && out_data.norm_y == 0 && out_data.norm_z == 0, "degenerate result carries a nonzero normal")

  `TFN_ASSERT_NOW(a_eom_last, out_valid && out_data.end_of_mesh, out_data.vertex_last, "end_of_mesh without vertex_last")

  `TFN_ASSERT_NOW(a_range, out_valid, out_data.norm_x >= -16384 && out_data.norm_x <= 16384 && out_data.norm_y >= -16384 && out_data.norm_y <= 16384 && out_data.norm_z >= -16384 && out_data.norm_z <= 16384, "normal component out of range")

  `TFN_ASSERT_NEXT(a_run_cont, out_valid && !out_stall && !out_data.vertex_last, out_valid && $stable(out_data.norm_x) && $stable(out_data.degenerate), "triangle run broken before its last copy")

  `TFN_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind triangle_face_normal_core tfn_checker u_tfn_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);

// ----- verif/triangle_face_normal_checker.sv -----
`timescale 1ns / 100ps

module triangle_face_normal_checker import tfn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  tfn_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  tfn_out_t out_data,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  output int       pending_normals,
  output int       mismatch_count
);

  tfn_out_t normals_due[$];
  logic     flip_q;

  function automatic logic signed [69:0] mul70(input logic signed [69:0] a,
                                               input logic signed [69:0] b);
    return a * b;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // unit normal in Q1.14; flags other than degenerate are filled in by the caller
  function automatic tfn_out_t face_normal(input tfn_in_t t, input logic flip);
    logic signed [32:0] e [3];
    logic signed [32:0] f [3];
    logic signed [69:0] n [3];
    logic [69:0]        mag [3];
    logic [63:0]        v [3];
    logic [63:0]        sum;
    logic [63:0]        len;
    logic [63:0]        q;
    logic [15:0]        res [3];
    int                 top;
    tfn_out_t           r;
    e[0] = {t.bx[31], t.bx} - {t.ax[31], t.ax};
    e[1] = {t.by[31], t.by} - {t.ay[31], t.ay};
    e[2] = {t.bz[31], t.bz} - {t.az[31], t.az};
    f[0] = {t.cx[31], t.cx} - {t.ax[31], t.ax};
    f[1] = {t.cy[31], t.cy} - {t.ay[31], t.ay};
    f[2] = {t.cz[31], t.cz} - {t.az[31], t.az};
    n[0] = mul70(e[1], f[2]) - mul70(e[2], f[1]);
    n[1] = mul70(e[2], f[0]) - mul70(e[0], f[2]);
    n[2] = mul70(e[0], f[1]) - mul70(e[1], f[0]);
    top = -1;
    for (int i = 0; i < 3; i++) begin
      mag[i] = n[i][69] ? -n[i] : n[i];
      for (int b = 0; b < 70; b++)
        if (mag[i][b] && b > top) top = b;
    end
    r = '0;
    if (top < 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (top > NORM_TOP) v[i] = 64'(mag[i] >> (top - NORM_TOP));
      else v[i] = 64'(mag[i] << (NORM_TOP - top));
      sum = sum + v[i] * v[i];
    end
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (v[i] * 64'd16384 + (len >> 1)) / len;
      res[i] = (n[i][69] != flip) ? 16'(-q) : 16'(q);
    end
    r.norm_x = res[0];
    r.norm_y = res[1];
    r.norm_z = res[2];
    return r;
  endfunction

  always @(posedge clk) begin
    tfn_out_t nrm;
    tfn_out_t want;
    if (!rst_n) begin
      flip_q <= 1'b0;
      normals_due.delete();
      pending_normals <= 0;
      mismatch_count <= 0;
    end else begin
      if (cfg_wr_en) flip_q <= cfg_wr_data;
      if (in_valid && !in_stall) begin
        nrm = face_normal(in_data, flip_q);
        for (int k = 0; k < 3; k++) begin
          nrm.vertex_last = (k == 2);
          nrm.end_of_mesh = (k == 2) && in_data.final_triangle;
          normals_due.push_back(nrm);
        end
      end
      if (out_valid && !out_stall) begin
        if (normals_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result transfer: %p", out_data);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = normals_due.pop_front();
          if (out_data !== want) begin
            if (mismatch_count < 10)
              $display("result mismatch: expected %p, got %p", want, out_data);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      pending_normals <= normals_due.size();
    end
  end

endmodule

// ----- verif/triangle_face_normal_core_tb.sv -----
`timescale 1ns / 100ps

module triangle_face_normal_core_tb import tfn_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 80;
  localparam int N_RANDOM    = 330;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  tfn_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tfn_out_t out_data;
  logic     cfg_wr_en = 1'b0;
  logic     cfg_wr_data = 1'b0;
  int       pending_normals;
  int       mismatch_count;
  int       cycles = 0;
  logic     gaps_on = 1'b1;

  always #2 clk = ~clk;

  triangle_face_normal_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  triangle_face_normal_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .pending_normals(pending_normals),
    .mismatch_count (mismatch_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver backpressure bursts
  initial begin
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_triangle(input tfn_in_t t);
    in_data = t;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    if (gaps_on && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 15)) @(negedge clk);
  endtask

  task automatic drain();
    while (pending_normals != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_flip(input logic value);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic tfn_in_t tri_of(input logic [31:0] ax, ay, az, bx, by, bz,
                                     cx, cy, cz, input logic fin);
    tfn_in_t t;
    t.ax = ax; t.ay = ay; t.az = az;
    t.bx = bx; t.by = by; t.bz = bz;
    t.cx = cx; t.cy = cy; t.cz = cz;
    t.final_triangle = fin;
    return t;
  endfunction

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20)) - 10);
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
                                             : 32'h80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic tfn_in_t random_triangle();
    tfn_in_t t;
    int      mode;
    int      k;
    mode = $urandom_range(0, 3);
    t = tri_of(rand_coord(mode), rand_coord(mode), rand_coord(mode),
               rand_coord(mode), rand_coord(mode), rand_coord(mode),
               rand_coord(mode), rand_coord(mode), rand_coord(mode),
               $urandom_range(0, 7) == 0);
    case ($urandom_range(0, 15))
      0: begin
        // collinear: c = a + 2(b - a)
        k = 2;
        t.cx = t.ax + k * (t.bx - t.ax);
        t.cy = t.ay + k * (t.by - t.ay);
        t.cz = t.az + k * (t.bz - t.az);
      end
      1: begin
        t.bx = t.ax; t.by = t.ay; t.bz = t.az;
      end
      default: ;
    endcase
    return t;
  endfunction

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < 2; ph++) begin
      write_flip(ph[0]);
      // unit triangles in each axis plane
      send_triangle(tri_of(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 1'b0));
      send_triangle(tri_of(0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 1'b0));
      send_triangle(tri_of(0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, 1'b1));
      // all vertices equal, and a collinear set: zero cross product
      send_triangle(tri_of(5, -7, 9, 5, -7, 9, 5, -7, 9, 1'b0));
      send_triangle(tri_of(0, 0, 0, 1, 2, 3, 2, 4, 6, 1'b1));
      // one-LSB triangle, needs the left normalizing shift
      send_triangle(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0));
      send_triangle(tri_of(3, 3, 3, 4, 4, 3, 3, 4, 4, 1'b0));
      // coordinate extremes, largest edge vectors
      send_triangle(tri_of(32'h80000000, 32'h80000000, 32'h80000000,
                           32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                           32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0));
      send_triangle(tri_of(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                           32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                           32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b1));
      send_triangle(tri_of(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                           32'h7FFFFFFF, 32'h80000000, 32'h00000000,
                           32'h80000000, 32'h00000000, 32'h7FFFFFFF, 1'b0));
      // equal-magnitude components
      send_triangle(tri_of(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 1'b0));
    end

    // sender holds until every result is back, then random traffic
    for (int ph = 0; ph < 4; ph++) begin
      write_flip(ph[0]);
      if (ph == 3) gaps_on = 1'b0;
      for (int i = 0; i < N_RANDOM / 4; i++) send_triangle(random_triangle());
    end

    drain();
    if (mismatch_count == 0 && pending_normals == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
